FILE: rtl/core/rrts_pkg.sv
// Shared constants and types for the round robin task scheduler.
package rrts_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int ID_W      = SLOT_W + 1;
	localparam int RUN_W     = SLOT_W + 1;
	localparam int OP_W      = 3;
	localparam int TID_W     = 4;
	localparam int AID_W     = 4;
	localparam int CTX_W     = 32;
	localparam int SLICE_W   = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [RUN_W-1:0] IDLE_SLOT = RUN_W'(NUM_SLOTS);

	typedef logic [1:0] slot_state_t;
	localparam slot_state_t ST_TERMINATED = 2'd0;
	localparam slot_state_t ST_READY      = 2'd1;
	localparam slot_state_t ST_RUNNING    = 2'd2;
	localparam slot_state_t ST_BLOCKED    = 2'd3;

	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_CREATE  = 3'd0;
	localparam op_t OP_TICK    = 3'd1;
	localparam op_t OP_YIELD   = 3'd2;
	localparam op_t OP_EXIT    = 3'd3;
	localparam op_t OP_BLOCK   = 3'd4;
	localparam op_t OP_UNBLOCK = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_SLICE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_CONTEXT = 1'd1;

endpackage

FILE: rtl/core/round_robin_task_scheduler_top.sv
// Round robin time slice task scheduler with a one-slot-per-cycle scan sequencer.
//
//  channel   signals                                              handshake
//  command   start, op, context_req, target_id                    start && !busy
//  result    done, status, assigned_id, running_slot,             done, one cycle
//            next_context, switched
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data            cfg_valid && cfg_ready
//
// An unknown op or a tick inside the slice answers in the cycle after acceptance.
// Create and unblock walk slots 1..NUM_SLOTS-1, one per cycle.
// A reschedule runs a save state (skipped while idle runs), a scan of up to NUM_SLOTS-1
// slots and then a context read or fallback state.
// busy drops in the result cycle; reset is asynchronous, the context RAM needs no clearing.
// Results cannot be stalled; each result shows for exactly one cycle.
module round_robin_task_scheduler_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [rrts_pkg::OP_W-1:0]           op,
	input  logic [rrts_pkg::CTX_W-1:0]          context_req,
	input  logic [rrts_pkg::TID_W-1:0]          target_id,
	output logic                                done,
	output logic                                status,
	output logic [rrts_pkg::AID_W-1:0]          assigned_id,
	output logic [rrts_pkg::RUN_W-1:0]          running_slot,
	output logic [rrts_pkg::CTX_W-1:0]          next_context,
	output logic                                switched,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rrts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rrts_pkg::CTX_W-1:0]          cfg_data
);

	localparam int SLOT_W = rrts_pkg::SLOT_W;
	localparam int ID_W   = rrts_pkg::ID_W;
	localparam int N      = rrts_pkg::NUM_SLOTS;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CREATE = 3'd1;
	localparam logic [2:0] S_UNBLK  = 3'd2;
	localparam logic [2:0] S_SAVE   = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_FALL   = 3'd5;
	localparam logic [2:0] S_READ   = 3'd6;

	logic [2:0]                         state_q;
	rrts_pkg::slot_state_t              slot_state_q [N];
	logic [ID_W-1:0]                    slot_id_q [N];
	logic [rrts_pkg::CTX_W-1:0]         ctx_mem [N];
	logic [rrts_pkg::CTX_W-1:0]         rd_q;
	logic [SLOT_W-1:0]                  idx_q;
	logic [SLOT_W-1:0]                  cnt_q;
	logic [SLOT_W-1:0]                  base_q;
	logic [SLOT_W-1:0]                  cur_q;
	logic                               idle_q;
	logic [rrts_pkg::SLICE_W-1:0]       tick_q;
	logic [ID_W-1:0]                    fresh_q;
	logic [rrts_pkg::SLICE_W-1:0]       slice_q;
	logic [rrts_pkg::CTX_W-1:0]         idle_ctx_q;
	rrts_pkg::op_t                      op_q;
	logic [rrts_pkg::CTX_W-1:0]         ctx_q;
	logic [rrts_pkg::TID_W-1:0]         tid_q;
	logic                               done_q;
	logic                               status_q;
	logic [rrts_pkg::AID_W-1:0]         aid_q;
	logic [rrts_pkg::CTX_W-1:0]         next_ctx_q;
	logic                               switched_q;

	rrts_pkg::slot_state_t              sel_state;
	logic [ID_W-1:0]                    sel_id;
	logic [ID_W-1:0]                    cr_id;
	logic                               cr_ok;
	logic                               idx_last;
	logic [SLOT_W-1:0]                  idx_next;
	logic [rrts_pkg::SLICE_W-1:0]       tick_inc;
	logic                               mem_we;

	assign sel_state = slot_state_q[idx_q];
	assign sel_id    = slot_id_q[idx_q];
	assign cr_id     = (sel_id == '0) ? fresh_q : sel_id;
	assign cr_ok     = (cr_id != '0) && (cr_id < ID_W'(N));
	assign idx_last  = (idx_q == SLOT_W'(N - 1));
	assign idx_next  = idx_last ? '0 : idx_q + 1'b1;
	assign tick_inc  = tick_q + 1'b1;
	assign mem_we    = (state_q == S_SAVE) ||
		((state_q == S_CREATE) && (sel_state == rrts_pkg::ST_TERMINATED) && cr_ok);

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign done         = done_q;
	assign status       = status_q;
	assign assigned_id  = aid_q;
	assign next_context = next_ctx_q;
	assign switched     = switched_q;
	assign running_slot = idle_q ? rrts_pkg::IDLE_SLOT : {1'b0, cur_q};

	// Context RAM: one address, registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ctx_mem[idx_q] <= ctx_q;
		end
		rd_q <= ctx_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q    <= rrts_pkg::SLICE_W'(10);
			idle_ctx_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rrts_pkg::CFG_SLICE_LENGTH: slice_q    <= cfg_data[rrts_pkg::SLICE_W-1:0];
				rrts_pkg::CFG_IDLE_CONTEXT: idle_ctx_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			for (int i = 0; i < N; i++) begin
				slot_state_q[i] <= rrts_pkg::ST_TERMINATED;
				slot_id_q[i]    <= '0;
			end
			slot_state_q[0] <= rrts_pkg::ST_RUNNING;
			idx_q      <= '0;
			cnt_q      <= '0;
			base_q     <= '0;
			cur_q      <= '0;
			idle_q     <= 1'b0;
			tick_q     <= '0;
			fresh_q    <= ID_W'(1);
			op_q       <= rrts_pkg::OP_CREATE;
			ctx_q      <= '0;
			tid_q      <= '0;
			done_q     <= 1'b0;
			status_q   <= 1'b0;
			aid_q      <= '0;
			next_ctx_q <= '0;
			switched_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q  <= op;
						ctx_q <= context_req;
						tid_q <= target_id;
						unique case (op)
							rrts_pkg::OP_CREATE: begin
								idx_q   <= SLOT_W'(1);
								state_q <= S_CREATE;
							end
							rrts_pkg::OP_UNBLOCK: begin
								idx_q   <= SLOT_W'(1);
								state_q <= S_UNBLK;
							end
							rrts_pkg::OP_TICK, rrts_pkg::OP_YIELD,
							rrts_pkg::OP_EXIT, rrts_pkg::OP_BLOCK: begin
								if ((op == rrts_pkg::OP_TICK) && (tick_inc < slice_q)) begin
									tick_q     <= tick_inc;
									done_q     <= 1'b1;
									status_q   <= 1'b0;
									aid_q      <= '0;
									next_ctx_q <= context_req;
									switched_q <= 1'b0;
								end else begin
									tick_q <= '0;
									cnt_q  <= SLOT_W'(1);
									if (idle_q) begin
										// idle runs: nothing to save, scan from slot 1
										base_q  <= '0;
										idx_q   <= SLOT_W'(1);
										state_q <= S_SCAN;
									end else begin
										base_q  <= cur_q;
										idx_q   <= cur_q;
										state_q <= S_SAVE;
									end
								end
							end
							default: begin
								done_q     <= 1'b1;
								status_q   <= 1'b1;
								aid_q      <= '0;
								next_ctx_q <= context_req;
								switched_q <= 1'b0;
							end
						endcase
					end
				end
				S_CREATE: begin
					if (sel_state == rrts_pkg::ST_TERMINATED) begin
						if (sel_id == '0) begin
							slot_id_q[idx_q] <= fresh_q;
							if (fresh_q < ID_W'(N)) begin
								fresh_q <= fresh_q + 1'b1;
							end
						end
						if (cr_ok) begin
							slot_state_q[idx_q] <= rrts_pkg::ST_READY;
						end
						status_q   <= !cr_ok;
						aid_q      <= cr_ok ? rrts_pkg::AID_W'(cr_id) : '0;
						next_ctx_q <= ctx_q;
						switched_q <= 1'b0;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else if (idx_last) begin
						status_q   <= 1'b1;
						aid_q      <= '0;
						next_ctx_q <= ctx_q;
						switched_q <= 1'b0;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						idx_q <= idx_next;
					end
				end
				S_UNBLK: begin
					if ((sel_id == ID_W'(tid_q)) && (sel_state == rrts_pkg::ST_BLOCKED)) begin
						slot_state_q[idx_q] <= rrts_pkg::ST_READY;
						status_q   <= 1'b0;
						aid_q      <= '0;
						next_ctx_q <= ctx_q;
						switched_q <= 1'b0;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else if (idx_last) begin
						status_q   <= 1'b1;
						aid_q      <= '0;
						next_ctx_q <= ctx_q;
						switched_q <= 1'b0;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						idx_q <= idx_next;
					end
				end
				S_SAVE: begin
					// context goes to RAM this cycle; retire or demote the current task
					priority if (op_q == rrts_pkg::OP_EXIT) begin
						slot_state_q[idx_q] <= rrts_pkg::ST_TERMINATED;
					end else if (op_q == rrts_pkg::OP_BLOCK) begin
						slot_state_q[idx_q] <= rrts_pkg::ST_BLOCKED;
					end else if (sel_state == rrts_pkg::ST_RUNNING) begin
						slot_state_q[idx_q] <= rrts_pkg::ST_READY;
					end
					idx_q   <= idx_next;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sel_state == rrts_pkg::ST_READY) begin
						slot_state_q[idx_q] <= rrts_pkg::ST_RUNNING;
						cur_q   <= idx_q;
						idle_q  <= 1'b0;
						state_q <= S_READ;
					end else if (cnt_q == SLOT_W'(N - 1)) begin
						idx_q   <= base_q;
						state_q <= S_FALL;
					end else begin
						idx_q <= idx_next;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FALL: begin
					// nobody else ready: keep the current task, else go idle
					if (!idle_q && (sel_state == rrts_pkg::ST_READY)) begin
						slot_state_q[idx_q] <= rrts_pkg::ST_RUNNING;
						next_ctx_q <= ctx_q;
					end else begin
						idle_q     <= 1'b1;
						next_ctx_q <= idle_ctx_q;
					end
					status_q   <= 1'b0;
					aid_q      <= '0;
					switched_q <= 1'b1;
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end
				S_READ: begin
					next_ctx_q <= rd_q;
					status_q   <= 1'b0;
					aid_q      <= '0;
					switched_q <= 1'b1;
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/rrts_checker.sv
// Port-level checker for the round robin task scheduler, bound to the top level.
module rrts_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic                           status,
	input logic [rrts_pkg::AID_W-1:0]     assigned_id,
	input logic [rrts_pkg::RUN_W-1:0]     running_slot,
	input logic                           switched
);

	// a result beat only shows once the sequencer is free again
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command neither busy nor answered");

	a_switch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && switched) |-> (!status && (assigned_id == '0)))
		else $error("reschedule beat with bad status or id");

	a_id_create: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (assigned_id != '0)) |-> (!status && !switched))
		else $error("assigned id on a failed or switching beat");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		running_slot <= rrts_pkg::IDLE_SLOT)
		else $error("running slot out of range");

endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.assigned_id  (assigned_id),
	.running_slot (running_slot),
	.switched     (switched)
);
